// ===== hw/rtl/c8ie_pkg.sv =====
`timescale 1ns / 1ps

package c8ie_pkg;

    // Machine geometry.
    localparam int MEM_BYTES   = 4096;
    localparam int MEM_AW      = $clog2(MEM_BYTES);
    localparam int STACK_DEPTH = 16;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SCREEN_W    = 64;
    localparam int SCREEN_H    = 32;
    localparam int ROW_AW      = $clog2(SCREEN_H);
    localparam int NUM_REGS    = 16;

    localparam logic [11:0] START_RESET = 12'h200;

    // Configuration register addresses.
    localparam logic [2:0] CFG_START_ADDR = 3'd0;

    // Input item kinds.
    localparam logic ITEM_LOAD = 1'b0;
    localparam logic ITEM_EXEC = 1'b1;

    // Instruction groups (top nibble).
    localparam logic [3:0] OP_SYS   = 4'h0;
    localparam logic [3:0] OP_JP    = 4'h1;
    localparam logic [3:0] OP_CALL  = 4'h2;
    localparam logic [3:0] OP_SEI   = 4'h3;
    localparam logic [3:0] OP_SNEI  = 4'h4;
    localparam logic [3:0] OP_SER   = 4'h5;
    localparam logic [3:0] OP_LDI   = 4'h6;
    localparam logic [3:0] OP_ADDI  = 4'h7;
    localparam logic [3:0] OP_ALU   = 4'h8;
    localparam logic [3:0] OP_SNER  = 4'h9;
    localparam logic [3:0] OP_LDIDX = 4'hA;
    localparam logic [3:0] OP_JPV0  = 4'hB;
    localparam logic [3:0] OP_RND   = 4'hC;
    localparam logic [3:0] OP_DRW   = 4'hD;
    localparam logic [3:0] OP_KEY   = 4'hE;
    localparam logic [3:0] OP_MISC  = 4'hF;

    localparam logic [15:0] INSTR_CLS = 16'h00E0;
    localparam logic [15:0] INSTR_RET = 16'h00EE;

    // ALU sub-operations (low nibble of 8XYn).
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    // Miscellaneous sub-operations (low byte of FXnn).
    localparam logic [7:0] MISC_GETDT = 8'h07;
    localparam logic [7:0] MISC_SETDT = 8'h15;
    localparam logic [7:0] MISC_SETST = 8'h18;
    localparam logic [7:0] MISC_ADDI  = 8'h1E;
    localparam logic [7:0] MISC_FONT  = 8'h29;
    localparam logic [7:0] MISC_BCD   = 8'h33;
    localparam logic [7:0] MISC_SAVE  = 8'h55;
    localparam logic [7:0] MISC_LOAD  = 8'h65;

    // Sequencer states.
    typedef enum logic [18:0] {
        ST_IDLE   = 19'h00001,
        ST_CLEAR  = 19'h00002,
        ST_FETCH0 = 19'h00004,
        ST_FETCH1 = 19'h00008,
        ST_FETCH2 = 19'h00010,
        ST_RDX    = 19'h00020,
        ST_RDY    = 19'h00040,
        ST_EXEC   = 19'h00080,
        ST_DRAW_A = 19'h00100,
        ST_DRAW_B = 19'h00200,
        ST_BCD    = 19'h00400,
        ST_SAVE_R = 19'h00800,
        ST_SAVE_W = 19'h01000,
        ST_LOAD_R = 19'h02000,
        ST_LOAD_W = 19'h04000,
        ST_FLAG   = 19'h08000,
        ST_EMIT_R = 19'h10000,
        ST_EMIT_W = 19'h20000,
        ST_DONE   = 19'h40000
    } state_t;

endpackage

// ===== hw/rtl/chip8_instruction_executor.sv =====
`timescale 1ns / 1ps

// CHIP-8 executor. A load request (tuser 0) writes one byte of the 4 KiB memory and returns
// one status result. An execute request (tuser 1) fetches, decodes and runs the instruction
// at the program counter through the single read port of the main memory and of the register
// file; a draw reads and writes one frame row per sprite row, FX33 writes its three digits in
// turn, FX55 and FX65 move one register at a time. After 00E0 or DXYN the 32 frame rows are
// read from the frame memory and sent in order, the last one with tlast; otherwise one status
// result is sent. One request is worked on at a time. After reset all 4096 bytes of the main
// memory are cleared in one pass, during which s_tready stays low.
module chip8_instruction_executor (
    input  logic         aclk,
    input  logic         aresetn,
    // Request channel.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // load_address[11:0], load_data[19:12], random_byte[27:20]
    input  logic [0:0]   s_tuser,   // opcode[0]
    // Result channel.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // pc_after[11:0], instruction_word[27:12],
                                    // screen_row[32:28], row_pixels[96:33], sound_active[97]
    output logic [0:0]   m_tuser,   // row_valid[0]
    output logic         m_tlast,
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import c8ie_pkg::*;

    state_t state_reg, state_next;

    logic [MEM_AW-1:0]   clr_reg, clr_next;
    logic [11:0]         pc_reg, pc_next;
    logic [11:0]         start_reg, start_next;
    logic [11:0]         i_reg, i_next;
    logic [SP_W-1:0]     sp_reg, sp_next;
    logic [7:0]          dt_reg, dt_next;
    logic [7:0]          st_reg, st_next;
    logic [15:0]         instr_reg, instr_next;
    logic [7:0]          hi_reg, hi_next;
    logic [7:0]          vx_reg, vx_next;
    logic [7:0]          vy_reg, vy_next;
    logic [11:0]         top_reg, top_next;
    logic [7:0]          rnd_reg, rnd_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [ROW_AW-1:0]   row_reg, row_next;
    logic                redraw_reg, redraw_next;
    logic                flag_reg, flag_next;
    logic [NUM_REGS-1:0] vvalid_reg, vvalid_next;
    logic [SCREEN_H-1:0] fvalid_reg, fvalid_next;
    logic                v_ok_reg, f_ok_reg;
    logic                mvalid_reg, mvalid_next;
    logic [103:0]        mdata_reg, mdata_next;
    logic                muser_reg, muser_next;
    logic                mlast_reg, mlast_next;

    // Memory ports.
    logic              mem_we;
    logic [MEM_AW-1:0] mem_wa, mem_ra;
    logic [7:0]        mem_wd, mem_rd;
    logic              v_we;
    logic [3:0]        v_wa, v_ra;
    logic [7:0]        v_wd, v_rd, v_val;
    logic                stk_we;
    logic [STACK_AW-1:0] stk_wa, stk_ra;
    logic [11:0]         stk_wd, stk_rd;
    logic              f_we;
    logic [ROW_AW-1:0] f_wa, f_ra;
    logic [63:0]       f_wd, f_rd, f_val;

    c8ie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_main (
        .aclk(aclk), .we(mem_we), .wa(mem_wa), .wd(mem_wd), .ra(mem_ra), .rd(mem_rd));
    c8ie_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_vreg (
        .aclk(aclk), .we(v_we), .wa(v_wa), .wd(v_wd), .ra(v_ra), .rd(v_rd));
    c8ie_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk(aclk), .we(stk_we), .wa(stk_wa), .wd(stk_wd), .ra(stk_ra), .rd(stk_rd));
    c8ie_ram #(.WIDTH(SCREEN_W), .DEPTH(SCREEN_H)) u_frame (
        .aclk(aclk), .we(f_we), .wa(f_wa), .wd(f_wd), .ra(f_ra), .rd(f_rd));

    // Entries never written since reset read as zero.
    assign v_val = v_ok_reg ? v_rd : 8'd0;
    assign f_val = f_ok_reg ? f_rd : 64'd0;

    // Instruction fields.
    logic [3:0]  op, x_idx, y_idx, n_val;
    logic [7:0]  nn;
    logic [11:0] nnn;
    assign op    = instr_reg[15:12];
    assign x_idx = instr_reg[11:8];
    assign y_idx = instr_reg[7:4];
    assign n_val = instr_reg[3:0];
    assign nn    = instr_reg[7:0];
    assign nnn   = instr_reg[11:0];

    // Datapath helpers.
    logic [11:0]     pc_inc2, pc_inc4, font_addr, i_off;
    logic [8:0]      add9;
    logic [12:0]     isum;
    logic [SP_W-1:0] sp_dec;
    logic [1:0]      hund;
    logic [7:0]      rem8, ones8, dt_set, st_set;
    logic [14:0]     tens_prod;
    logic [3:0]      tens;
    logic [63:0]     spr64, mask;
    logic [127:0]    spr_rot;
    logic            s_accept, cfg_we, out_free;

    assign pc_inc2   = pc_reg + 12'd2;
    assign pc_inc4   = pc_reg + 12'd4;
    assign add9      = {1'b0, vx_reg} + {1'b0, vy_reg};
    assign isum      = {1'b0, i_reg} + {5'b0, vx_reg};
    assign font_addr = {2'b0, vx_reg, 2'b0} + {4'b0, vx_reg};
    assign i_off     = i_reg + {8'b0, cnt_reg};
    assign sp_dec    = sp_reg - SP_W'(1);

    // Decimal digits: hundreds by compare, tens by reciprocal multiply (exact for every 7-bit remainder).
    assign hund      = (vx_reg >= 8'd200) ? 2'd2 : ((vx_reg >= 8'd100) ? 2'd1 : 2'd0);
    assign rem8      = vx_reg - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0));
    assign tens_prod = {8'b0, rem8[6:0]} * 15'd205;
    assign tens      = tens_prod[14:11];
    assign ones8     = rem8 - {1'b0, tens, 3'b0} - {3'b0, tens, 1'b0};

    // Sprite byte placed at column VX, wrapping around the row.
    assign spr64   = {mem_rd, 56'd0};
    assign spr_rot = {spr64, spr64} >> vx_reg[5:0];
    assign mask    = spr_rot[63:0];

    assign dt_set = (op == OP_MISC && nn == MISC_SETDT) ? vx_reg : dt_reg;
    assign st_set = (op == OP_MISC && nn == MISC_SETST) ? vx_reg : st_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;
    assign cfg_we   = psel && penable && pwrite && (paddr == CFG_START_ADDR);
    assign pready   = 1'b1;
    assign prdata   = (paddr == CFG_START_ADDR) ? {20'd0, start_reg} : 32'd0;

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;
    assign m_tlast  = mlast_reg;

    // Sequencer and datapath.
    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        pc_next     = pc_reg;
        start_next  = start_reg;
        i_next      = i_reg;
        sp_next     = sp_reg;
        dt_next     = dt_reg;
        st_next     = st_reg;
        instr_next  = instr_reg;
        hi_next     = hi_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        top_next    = top_reg;
        rnd_next    = rnd_reg;
        cnt_next    = cnt_reg;
        row_next    = row_reg;
        redraw_next = redraw_reg;
        flag_next   = flag_reg;
        vvalid_next = vvalid_reg;
        fvalid_next = fvalid_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        mlast_next  = mlast_reg;

        mem_we = 1'b0;
        mem_wa = i_off;
        mem_wd = 8'd0;
        mem_ra = pc_reg;
        v_we   = 1'b0;
        v_wa   = x_idx;
        v_wd   = 8'd0;
        v_ra   = hi_reg[3:0];
        stk_we = 1'b0;
        stk_wa = sp_reg[STACK_AW-1:0];
        stk_wd = pc_reg;
        stk_ra = sp_dec[STACK_AW-1:0];
        f_we   = 1'b0;
        f_ra   = row_reg;
        f_wa   = vy_reg[ROW_AW-1:0] + {1'b0, cnt_reg};
        f_wd   = f_val ^ mask;

        case (state_reg)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                clr_next = clr_reg + MEM_AW'(1);
                if (&clr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    rnd_next = s_tdata[27:20];
                    if (s_tuser[0] == ITEM_LOAD) begin
                        mem_we     = 1'b1;
                        mem_wa     = s_tdata[11:0];
                        mem_wd     = s_tdata[19:12];
                        instr_next = 16'd0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_FETCH0;
                    end
                end
            end
            ST_FETCH0: begin
                mem_ra     = pc_reg;
                state_next = ST_FETCH1;
            end
            ST_FETCH1: begin
                hi_next    = mem_rd;
                mem_ra     = pc_reg + 12'd1;
                state_next = ST_FETCH2;
            end
            ST_FETCH2: begin
                instr_next = {hi_reg, mem_rd};
                v_ra       = hi_reg[3:0];
                state_next = ST_RDX;
            end
            ST_RDX: begin
                vx_next    = v_val;
                top_next   = stk_rd;
                v_ra       = (op == OP_JPV0) ? 4'd0 : y_idx;
                state_next = ST_RDY;
            end
            ST_RDY: begin
                vy_next    = v_val;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                pc_next     = pc_inc2;
                redraw_next = 1'b0;
                flag_next   = 1'b0;
                cnt_next    = 4'd0;
                row_next    = '0;
                state_next  = ST_DONE;
                dt_next     = (dt_set != 8'd0) ? dt_set - 8'd1 : 8'd0;
                st_next     = (st_set != 8'd0) ? st_set - 8'd1 : 8'd0;
                case (op)
                    OP_SYS: begin
                        if (instr_reg == INSTR_CLS) begin
                            fvalid_next = '0;
                            state_next  = ST_EMIT_R;
                        end else if (instr_reg == INSTR_RET && sp_reg != '0) begin
                            sp_next = sp_dec;
                            pc_next = top_reg + 12'd2;
                        end
                    end
                    OP_JP: pc_next = nnn;
                    OP_CALL: begin
                        if (sp_reg < SP_W'(STACK_DEPTH)) begin
                            stk_we  = 1'b1;
                            sp_next = sp_reg + SP_W'(1);
                        end
                        pc_next = nnn;
                    end
                    OP_SEI:  if (vx_reg == nn) pc_next = pc_inc4;
                    OP_SNEI: if (vx_reg != nn) pc_next = pc_inc4;
                    OP_SER:  if (vx_reg == vy_reg) pc_next = pc_inc4;
                    OP_SNER: if (vx_reg != vy_reg) pc_next = pc_inc4;
                    OP_LDI: begin
                        v_we = 1'b1;
                        v_wd = nn;
                    end
                    OP_ADDI: begin
                        v_we = 1'b1;
                        v_wd = vx_reg + nn;
                    end
                    OP_ALU: begin
                        v_we       = 1'b1;
                        state_next = ST_FLAG;
                        case (n_val)
                            ALU_MOV: begin
                                v_wd = vy_reg;
                                state_next = ST_DONE;
                            end
                            ALU_OR: begin
                                v_wd = vx_reg | vy_reg;
                                state_next = ST_DONE;
                            end
                            ALU_AND: begin
                                v_wd = vx_reg & vy_reg;
                                state_next = ST_DONE;
                            end
                            ALU_XOR: begin
                                v_wd = vx_reg ^ vy_reg;
                                state_next = ST_DONE;
                            end
                            ALU_ADD: begin
                                v_wd      = add9[7:0];
                                flag_next = add9[8];
                            end
                            ALU_SUB: begin
                                v_wd      = vx_reg - vy_reg;
                                flag_next = (vx_reg >= vy_reg);
                            end
                            ALU_SHR: begin
                                v_wd      = {1'b0, vx_reg[7:1]};
                                flag_next = vx_reg[0];
                            end
                            ALU_SBN: begin
                                v_wd      = vy_reg - vx_reg;
                                flag_next = (vy_reg >= vx_reg);
                            end
                            ALU_SHL: begin
                                v_wd      = {vx_reg[6:0], 1'b0};
                                flag_next = vx_reg[7];
                            end
                            default: begin
                                v_we       = 1'b0;
                                state_next = ST_DONE;
                            end
                        endcase
                    end
                    OP_LDIDX: i_next = nnn;
                    OP_JPV0:  pc_next = nnn + {4'd0, vy_reg};
                    OP_RND: begin
                        v_we = 1'b1;
                        v_wd = rnd_reg & nn;
                    end
                    OP_DRW: begin
                        redraw_next = 1'b1;
                        state_next  = (n_val == 4'd0) ? ST_FLAG : ST_DRAW_A;
                    end
                    OP_KEY: begin
                        pc_next = pc_inc2;
                    end
                    OP_MISC: begin
                        case (nn)
                            MISC_GETDT: begin
                                v_we = 1'b1;
                                v_wd = dt_reg;
                            end
                            MISC_ADDI: begin
                                i_next     = isum[11:0];
                                flag_next  = isum[12];
                                state_next = ST_FLAG;
                            end
                            MISC_FONT: i_next = font_addr;
                            MISC_BCD:  state_next = ST_BCD;
                            MISC_SAVE: state_next = ST_SAVE_R;
                            MISC_LOAD: state_next = ST_LOAD_R;
                            default: begin
                                pc_next = pc_inc2;
                            end
                        endcase
                    end
                    default: begin
                        pc_next = pc_inc2;
                    end
                endcase
            end
            ST_DRAW_A: begin
                mem_ra     = i_off;
                f_ra       = f_wa;
                state_next = ST_DRAW_B;
            end
            ST_DRAW_B: begin
                f_ra        = f_wa;
                f_we        = 1'b1;
                fvalid_next[f_wa] = 1'b1;
                flag_next   = flag_reg | (|(f_val & mask));
                cnt_next    = cnt_reg + 4'd1;
                state_next  = (cnt_reg == n_val - 4'd1) ? ST_FLAG : ST_DRAW_A;
            end
            ST_BCD: begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 4'd1;
                case (cnt_reg[1:0])
                    2'd0:    mem_wd = {6'd0, hund};
                    2'd1:    mem_wd = {4'd0, tens};
                    default: mem_wd = ones8;
                endcase
                if (cnt_reg[1:0] == 2'd2) begin
                    state_next = ST_DONE;
                end
            end
            ST_SAVE_R: begin
                v_ra       = cnt_reg;
                state_next = ST_SAVE_W;
            end
            ST_SAVE_W: begin
                mem_we = 1'b1;
                mem_wd = v_val;
                if (cnt_reg == x_idx) begin
                    i_next     = i_reg + {8'd0, x_idx} + 12'd1;
                    state_next = ST_DONE;
                end else begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = ST_SAVE_R;
                end
            end
            ST_LOAD_R: begin
                mem_ra     = i_off;
                state_next = ST_LOAD_W;
            end
            ST_LOAD_W: begin
                v_we = 1'b1;
                v_wa = cnt_reg;
                v_wd = mem_rd;
                vvalid_next[cnt_reg] = 1'b1;
                if (cnt_reg == x_idx) begin
                    i_next     = i_reg + {8'd0, x_idx} + 12'd1;
                    state_next = ST_DONE;
                end else begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = ST_LOAD_R;
                end
            end
            ST_FLAG: begin
                v_we       = 1'b1;
                v_wa       = 4'd15;
                v_wd       = {7'd0, flag_reg};
                state_next = redraw_reg ? ST_EMIT_R : ST_DONE;
            end
            ST_EMIT_R: begin
                f_ra       = row_reg;
                state_next = ST_EMIT_W;
            end
            ST_EMIT_W: begin
                f_ra = row_reg;
                if (out_free) begin
                    mvalid_next = 1'b1;
                    muser_next  = 1'b1;
                    mlast_next  = (row_reg == ROW_AW'(SCREEN_H - 1));
                    mdata_next  = {6'd0, (st_reg != 8'd0), f_val, row_reg, instr_reg, pc_reg};
                    row_next    = row_reg + ROW_AW'(1);
                    state_next  = (row_reg == ROW_AW'(SCREEN_H - 1)) ? ST_IDLE : ST_EMIT_R;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    muser_next  = 1'b0;
                    mlast_next  = 1'b1;
                    mdata_next  = {6'd0, (st_reg != 8'd0), 64'd0, 5'd0, instr_reg, pc_reg};
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (v_we) begin
            vvalid_next[v_wa] = 1'b1;
        end

        // A start address write also loads the program counter.
        if (cfg_we) begin
            start_next = pwdata[11:0];
            pc_next    = pwdata[11:0];
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            pc_reg     <= START_RESET;
            start_reg  <= START_RESET;
            i_reg      <= 12'd0;
            sp_reg     <= '0;
            dt_reg     <= 8'd0;
            st_reg     <= 8'd0;
            vvalid_reg <= '0;
            fvalid_reg <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            pc_reg     <= pc_next;
            start_reg  <= start_next;
            i_reg      <= i_next;
            sp_reg     <= sp_next;
            dt_reg     <= dt_next;
            st_reg     <= st_next;
            vvalid_reg <= vvalid_next;
            fvalid_reg <= fvalid_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        instr_reg  <= instr_next;
        hi_reg     <= hi_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        top_reg    <= top_next;
        rnd_reg    <= rnd_next;
        cnt_reg    <= cnt_next;
        row_reg    <= row_next;
        redraw_reg <= redraw_next;
        flag_reg   <= flag_next;
        v_ok_reg   <= vvalid_reg[v_ra];
        f_ok_reg   <= fvalid_reg[f_ra];
        mdata_reg  <= mdata_next;
        muser_reg  <= muser_next;
        mlast_reg  <= mlast_next;
    end

    // The return stack never holds more than its depth.
    assert property (@(posedge aclk) disable iff (!aresetn) sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack depth overflow");

    // One request at a time: no request is taken right after one was accepted.
    assert property (@(posedge aclk) disable iff (!aresetn) s_accept |=> !s_tready)
        else $error("request accepted while busy");

    // A status result always carries tlast, being the only result of its request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("status result without last");

    // The last row of a redraw is the bottom row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0] && m_tlast) |-> (m_tdata[32:28] == 5'd31))
        else $error("redraw ended early");

    // Nothing is accepted during the memory clearing pass.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("request taken while clearing");

endmodule

// ===== hw/rtl/c8ie_ram.sv =====
`timescale 1ns / 1ps

module c8ie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    wa,
    input  logic [WIDTH-1:0] wd,
    input  logic [AW-1:0]    ra,
    output logic [WIDTH-1:0] rd
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd <= mem[ra];
    end

endmodule
